// ===== rtl/rrle_pkg.sv =====
// Shared types, codes and the RGBE to binary32 conversion for the RGBE
// scanline decoder. No dependencies.
`default_nettype none

package rrle_pkg;

  localparam logic [1:0] ST_PIXELS = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_BAD_WIDTH = 2'd2;
  localparam logic [1:0] ST_BAD_COUNT = 2'd3;

  localparam logic [1:0] CH_RED = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE = 2'd2;
  localparam logic [1:0] CH_EXPONENT = 2'd3;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic        is_err;
    logic [1:0]  status;
    logic [7:0]  value;
    logic [7:0]  count;
    logic [12:0] col;
    logic [1:0]  chan;
    logic [15:0] row;
    logic [12:0] width;
  } cmd_t;

  typedef struct packed {
    logic [31:0] first_red;
    logic [31:0] first_green;
    logic [31:0] first_blue;
    logic [31:0] second_red;
    logic [31:0] second_green;
    logic [31:0] second_blue;
    logic        second_valid;
    logic [11:0] first_column;
    logic [15:0] row_index;
    logic        end_of_line;
    logic        last_of_run;
    logic [1:0]  status;
  } res_t;

  function automatic logic [31:0] to_f32(input logic [7:0] m, input logic [7:0] e);
    logic [2:0]  p;
    logic [8:0]  sum;
    logic [8:0]  biased;
    logic [7:0]  shifted;
    logic [31:0] r;
    p = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (m[i]) begin
        p = 3'(i);
      end
    end
    sum = 9'(p) + 9'(e);
    biased = sum - 9'd9;
    shifted = m << (3'd7 - p);
    if (m == 8'd0 || e == 8'd0) begin
      r = 32'd0;
    end else if (sum >= 9'd10) begin
      r = {1'b0, biased[7:0], shifted[6:0], 16'd0};
    end else begin
      r = 32'(m) << (e[4:0] + 5'd13);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rrle_fifo.sv =====
// Two-entry queue used between the parser and the expander and on the result side.
// Depends on nothing.
`default_nettype none

module rrle_fifo #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrle_front.sv =====
// Byte parser: checks scanline headers and counts, turns each value byte into a
// store command and each bad header or count into an error command. Depends on rrle_pkg.
`default_nettype none

module rrle_front #(
  parameter int MaxWidth = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic [12:0]   width_i,
  input  wire logic [15:0]   height_i,
  output logic               cmd_push_o,
  output rrle_pkg::cmd_t     cmd_o
);
  import rrle_pkg::*;

  typedef enum logic [6:0] {
    PH_H0    = 7'b0000001,
    PH_H1    = 7'b0000010,
    PH_H2    = 7'b0000100,
    PH_H3    = 7'b0001000,
    PH_COUNT = 7'b0010000,
    PH_RUN   = 7'b0100000,
    PH_LIT   = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  chan_q, chan_d;
  logic [12:0] col_q, col_d;
  logic [7:0]  rem_q, rem_d;
  logic [6:0]  hw_q, hw_d;
  logic [15:0] line_q, line_d;
  logic        stop_q, stop_d;
  logic        wok;
  logic [12:0] room;
  logic [12:0] span;
  logic [7:0]  run_n;
  logic        line_done;

  assign wok = (width_i != 13'd0) && (32'(width_i) <= MaxWidth);
  assign room = (wok && col_q < width_i) ? width_i - col_q : 13'd0;
  assign span = width_i - col_q;
  assign run_n = byte_i - 8'd128;
  assign line_done = (chan_q == CH_EXPONENT);

  always_comb begin
    phase_d = phase_q;
    chan_d = chan_q;
    col_d = col_q;
    rem_d = rem_q;
    hw_d = hw_q;
    line_d = line_q;
    stop_d = stop_q;
    cmd_push_o = 1'b0;
    cmd_o.is_err = 1'b0;
    cmd_o.status = ST_PIXELS;
    cmd_o.value = byte_i;
    cmd_o.count = 8'd1;
    cmd_o.col = col_q;
    cmd_o.chan = chan_q;
    cmd_o.row = line_q;
    cmd_o.width = width_i;
    if (accept_i && !stop_q && line_q < height_i) begin
      unique case (phase_q)
        PH_H0: begin
          if (byte_i != 8'd2) begin
            cmd_push_o = 1'b1;
            cmd_o.is_err = 1'b1;
            cmd_o.status = ST_BAD_HEADER;
            stop_d = 1'b1;
          end else begin
            phase_d = PH_H1;
          end
        end
        PH_H1: begin
          if (byte_i != 8'd2) begin
            cmd_push_o = 1'b1;
            cmd_o.is_err = 1'b1;
            cmd_o.status = ST_BAD_HEADER;
            stop_d = 1'b1;
          end else begin
            phase_d = PH_H2;
          end
        end
        PH_H2: begin
          if (byte_i[7]) begin
            cmd_push_o = 1'b1;
            cmd_o.is_err = 1'b1;
            cmd_o.status = ST_BAD_HEADER;
            stop_d = 1'b1;
          end else begin
            hw_d = byte_i[6:0];
            phase_d = PH_H3;
          end
        end
        PH_H3: begin
          if (!wok || {hw_q, byte_i} != {2'b00, width_i}) begin
            cmd_push_o = 1'b1;
            cmd_o.is_err = 1'b1;
            cmd_o.status = ST_BAD_WIDTH;
            stop_d = 1'b1;
          end else begin
            phase_d = PH_COUNT;
            chan_d = CH_RED;
            col_d = 13'd0;
          end
        end
        PH_COUNT: begin
          if (byte_i > 8'd128) begin
            if (13'(run_n) > room) begin
              cmd_push_o = 1'b1;
              cmd_o.is_err = 1'b1;
              cmd_o.status = ST_BAD_COUNT;
              stop_d = 1'b1;
            end else begin
              rem_d = run_n;
              phase_d = PH_RUN;
            end
          end else if (byte_i == 8'd0 || 13'(byte_i) > room) begin
            cmd_push_o = 1'b1;
            cmd_o.is_err = 1'b1;
            cmd_o.status = ST_BAD_COUNT;
            stop_d = 1'b1;
          end else begin
            rem_d = byte_i;
            phase_d = PH_LIT;
          end
        end
        PH_RUN: begin
          cmd_push_o = 1'b1;
          rem_d = 8'd0;
          phase_d = PH_COUNT;
          if (col_q < width_i && 13'(rem_q) < span) begin
            cmd_o.count = rem_q;
            col_d = col_q + 13'(rem_q);
          end else begin
            cmd_o.count = (col_q < width_i) ? span[7:0] : 8'd1;
            col_d = 13'd0;
            if (line_done) begin
              chan_d = CH_RED;
              line_d = line_q + 16'd1;
              phase_d = PH_H0;
            end else begin
              chan_d = chan_q + 2'd1;
            end
          end
        end
        PH_LIT: begin
          cmd_push_o = 1'b1;
          rem_d = (rem_q != 8'd0) ? rem_q - 8'd1 : 8'd0;
          phase_d = (rem_d != 8'd0) ? PH_LIT : PH_COUNT;
          if (14'(col_q) + 14'd1 >= 14'(width_i)) begin
            rem_d = 8'd0;
            col_d = 13'd0;
            if (line_done) begin
              chan_d = CH_RED;
              line_d = line_q + 16'd1;
              phase_d = PH_H0;
            end else begin
              chan_d = chan_q + 2'd1;
              phase_d = PH_COUNT;
            end
          end else begin
            col_d = col_q + 13'd1;
          end
        end
        default: begin
          phase_d = PH_H0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_H0;
      chan_q <= CH_RED;
      col_q <= 13'd0;
      rem_q <= 8'd0;
      hw_q <= 7'd0;
      line_q <= 16'd0;
      stop_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      chan_q <= chan_d;
      col_q <= col_d;
      rem_q <= rem_d;
      hw_q <= hw_d;
      line_q <= line_d;
      stop_q <= stop_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrle_back.sv =====
// Expander: carries out store commands one column per step, keeps the line
// store, converts pixels, pairs them into results and passes errors on. Depends on rrle_pkg.
`default_nettype none

module rrle_back #(
  parameter int MaxWidth = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_empty_i,
  input  wire rrle_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output rrle_pkg::res_t     res_o
);
  import rrle_pkg::*;

  localparam int AddrW = $clog2(MaxWidth);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WORK = 4'b0010,
    S_CONV = 4'b0100,
    S_ERR  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [7:0]  left_q, left_d;
  logic        pend_v_q, pend_v_d;
  logic [31:0] pend_r_q, pend_r_d, pend_g_q, pend_g_d, pend_b_q, pend_b_d;
  logic [7:0]  mem_r [MaxWidth];
  logic [7:0]  mem_g [MaxWidth];
  logic [7:0]  mem_b [MaxWidth];
  logic [7:0]  rd_r_q, rd_g_q, rd_b_q;
  logic        rd_ok_q;
  logic        in_range;
  logic [AddrW-1:0] addr;
  logic        wr_en, rd_en;
  logic [31:0] fr, fg, fb;
  logic        last_col, emit, final_res;

  assign in_range = 32'(cur_q.col) < MaxWidth;
  assign addr = AddrW'(cur_q.col);
  assign fr = to_f32(rd_ok_q ? rd_r_q : 8'd0, cur_q.value);
  assign fg = to_f32(rd_ok_q ? rd_g_q : 8'd0, cur_q.value);
  assign fb = to_f32(rd_ok_q ? rd_b_q : 8'd0, cur_q.value);
  assign last_col = (14'(cur_q.col) + 14'd1) >= 14'(cur_q.width);
  assign emit = cur_q.col[0] || last_col;
  assign final_res = (left_q == 8'd1) || ((left_q == 8'd2) && cur_q.col[0]
                     && !((14'(cur_q.col) + 14'd2) >= 14'(cur_q.width)));

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    left_d = left_q;
    pend_v_d = pend_v_q;
    pend_r_d = pend_r_q;
    pend_g_d = pend_g_q;
    pend_b_d = pend_b_q;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    wr_en = 1'b0;
    rd_en = 1'b0;
    res_o = '0;
    res_o.row_index = cur_q.row;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d = cmd_i;
          left_d = cmd_i.count;
          state_d = cmd_i.is_err ? S_ERR : S_WORK;
        end
      end
      S_WORK: begin
        if (cur_q.chan == CH_EXPONENT) begin
          rd_en = 1'b1;
          state_d = S_CONV;
        end else begin
          wr_en = in_range;
          cur_d.col = cur_q.col + 13'd1;
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            state_d = S_IDLE;
          end
        end
      end
      S_CONV: begin
        res_o.end_of_line = last_col;
        res_o.last_of_run = final_res;
        if (cur_q.col[0]) begin
          res_o.first_red = pend_v_q ? pend_r_q : 32'd0;
          res_o.first_green = pend_v_q ? pend_g_q : 32'd0;
          res_o.first_blue = pend_v_q ? pend_b_q : 32'd0;
          res_o.second_red = fr;
          res_o.second_green = fg;
          res_o.second_blue = fb;
          res_o.second_valid = 1'b1;
          res_o.first_column = 12'(cur_q.col - 13'd1);
        end else begin
          res_o.first_red = fr;
          res_o.first_green = fg;
          res_o.first_blue = fb;
          res_o.first_column = cur_q.col[11:0];
        end
        if (!(emit && res_full_i)) begin
          res_push_o = emit;
          if (emit) begin
            pend_v_d = 1'b0;
          end else begin
            pend_v_d = 1'b1;
            pend_r_d = fr;
            pend_g_d = fg;
            pend_b_d = fb;
          end
          cur_d.col = cur_q.col + 13'd1;
          left_d = left_q - 8'd1;
          state_d = (left_q == 8'd1) ? S_IDLE : S_WORK;
        end
      end
      S_ERR: begin
        res_o.status = cur_q.status;
        res_o.last_of_run = 1'b1;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      left_q <= 8'd0;
      pend_v_q <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q <= left_d;
      pend_v_q <= pend_v_d;
      if (rd_en) begin
        rd_ok_q <= in_range;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pend_r_q <= pend_r_d;
    pend_g_q <= pend_g_d;
    pend_b_q <= pend_b_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && cur_q.chan == CH_RED) begin
      mem_r[addr] <= cur_q.value;
    end
    if (wr_en && cur_q.chan == CH_GREEN) begin
      mem_g[addr] <= cur_q.value;
    end
    if (wr_en && cur_q.chan == CH_BLUE) begin
      mem_b[addr] <= cur_q.value;
    end
    if (rd_en) begin
      rd_r_q <= mem_r[addr];
      rd_g_q <= mem_g[addr];
      rd_b_q <= mem_b[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgbe_rle_scanline_decoder_unit.sv =====
// Top level of the RGBE run-length scanline decoder: configuration registers,
// parser, command queue, expander and result queue. Depends on rrle_pkg, rrle_front, rrle_fifo and rrle_back.
//
//   Channel   Handshake          Payload
//   input     push / full        stream_byte_i
//   result    pop / empty        pixel pair fields, status
//   config    cfg_we_i           cfg_index_i, cfg_data_i
//
// The parser takes one byte per cycle while the command queue has room.
// The expander fetches a command in its idle state, then writes a color channel to the
// line store in its work state, column by column, and for the exponent channel reads
// each column in the work state and converts it in the conversion state, emitting pairs.
// Reset clears all control state; the line store holds no valid data after reset.
// A full result queue stalls the expander, which in turn fills the command queue.
`default_nettype none

module rgbe_rle_scanline_decoder_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  stream_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      first_red_o,
  output logic [31:0]      first_green_o,
  output logic [31:0]      first_blue_o,
  output logic [31:0]      second_red_o,
  output logic [31:0]      second_green_o,
  output logic [31:0]      second_blue_o,
  output logic             second_valid_o,
  output logic [11:0]      first_column_o,
  output logic [15:0]      row_index_o,
  output logic             end_of_line_o,
  output logic             last_of_run_o,
  output logic [1:0]       status_o
);
  import rrle_pkg::*;

  logic [12:0] width_q;
  logic [15:0] height_q;
  logic        cmd_push, cmd_pop, cmd_empty;
  cmd_t        cmd_in, cmd_out;
  logic        res_push, res_full;
  res_t        res_in, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 13'd1;
      height_q <= 16'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) begin
        width_q <= cfg_data_i[12:0];
      end
      if (cfg_index_i == CFG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  rrle_front #(.MaxWidth(MAX_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (push && !full),
    .byte_i     (stream_byte_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  rrle_fifo #(.Width($bits(cmd_t))) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  rrle_back #(.MaxWidth(MAX_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  rrle_fifo #(.Width($bits(res_t))) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign first_red_o = res_out.first_red;
  assign first_green_o = res_out.first_green;
  assign first_blue_o = res_out.first_blue;
  assign second_red_o = res_out.second_red;
  assign second_green_o = res_out.second_green;
  assign second_blue_o = res_out.second_blue;
  assign second_valid_o = res_out.second_valid;
  assign first_column_o = res_out.first_column;
  assign row_index_o = res_out.row_index;
  assign end_of_line_o = res_out.end_of_line;
  assign last_of_run_o = res_out.last_of_run;
  assign status_o = res_out.status;

endmodule

`default_nettype wire
